/* hdl/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Shared codes, field widths and item types of the texture transform engine.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int PIXEL_W     = 32;
  localparam int MODE_W      = 3;
  localparam int SIZE_REG_W  = 9;
  localparam int ORIGIN_W    = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Output modes; unlisted codes act as copy
  localparam logic [MODE_W-1:0] MODE_COPY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HMIRROR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VMIRROR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CROP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SCALE   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_W  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_H  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_W  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_H  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CROP_X = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CROP_Y = 3'd6;

  typedef struct packed {
    logic               opcode;
    logic [PIXEL_W-1:0] pixel_in;
  } tte_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               last_pixel;
    logic               out_of_range;
  } tte_out_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAP,
    BK_DIV,
    BK_ADDR,
    BK_READ
  } tte_back_state_t;

endpackage

/* hdl/tte_ram.sv */
// ----------------------------------------------------------------------------
// tte_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/tte_fifo.sv */
// ----------------------------------------------------------------------------
// tte_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tte_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTRW-1:0]  wptr;
  logic [PTRW-1:0]  rptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNTW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rptr];

  // Store an item at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTRW'(DEPTH - 1)) ? '0 : wptr + PTRW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTRW'(DEPTH - 1)) ? '0 : rptr + PTRW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

/* hdl/tte_front.sv */
// ----------------------------------------------------------------------------
// tte_front
// Accepts items, tracks write and output raster positions, and queues commands.
// ----------------------------------------------------------------------------
module tte_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  parameter int SZW  = $clog2(MAX_WIDTH + 1),
  parameter int SZH  = $clog2(MAX_HEIGHT + 1),
  parameter int AW   = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1,
  parameter int CMDW = 2 + 32 + AW + XW + YW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  restart,
  input  logic                  push,
  output logic                  full,
  input  tte_pkg::tte_in_t      request,
  input  logic [2:0]            mode,
  input  logic [SZW-1:0]        sw,
  input  logic [SZH-1:0]        sh,
  input  logic [SZW-1:0]        dw,
  input  logic [SZH-1:0]        dh,
  output logic                  cmd_push,
  output logic [CMDW-1:0]       cmd_data,
  input  logic                  cmd_full
);

  import tte_pkg::*;

  localparam int PW   = SZW + SZH;
  localparam int NW   = (AW + 1 > PW) ? AW + 1 : PW;
  localparam int CMPX = (XW > SZW) ? XW : SZW;
  localparam int CMPY = (YW > SZH) ? YW : SZH;

  logic [AW-1:0]  wp;
  logic [AW-1:0]  wp_next;
  logic [XW-1:0]  col;
  logic [XW-1:0]  col_next;
  logic [YW-1:0]  row;
  logic [YW-1:0]  row_next;

  logic           accept;
  logic           is_fetch;
  logic [PW-1:0]  pix_count;
  logic [AW-1:0]  wr_addr;
  logic [NW-1:0]  wr_inc;
  logic           crop_scale;
  logic [SZW-1:0] ow;
  logic [SZH-1:0] oh;
  logic [SZW-1:0] ow_m1;
  logic [SZH-1:0] oh_m1;
  logic [XW-1:0]  x;
  logic [YW-1:0]  y;
  logic           col_end;
  logic           row_end;
  logic           last;

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign is_fetch = (request.opcode == OP_FETCH);
  assign cmd_push = accept;

  // Source write position, wrapping at the image size
  assign pix_count = sw * sh;
  assign wr_addr   = (NW'(wp) >= NW'(pix_count)) ? '0 : wp;
  assign wr_inc    = NW'(wr_addr) + NW'(1);

  // Output frame size and clamped output position
  assign crop_scale = (mode == MODE_CROP) || (mode == MODE_SCALE);
  assign ow      = crop_scale ? dw : sw;
  assign oh      = crop_scale ? dh : sh;
  assign ow_m1   = ow - SZW'(1);
  assign oh_m1   = oh - SZH'(1);
  assign x       = (CMPX'(col) < CMPX'(ow)) ? col : XW'(ow_m1);
  assign y       = (CMPY'(row) < CMPY'(oh)) ? row : YW'(oh_m1);
  assign col_end = (CMPX'(x) == CMPX'(ow_m1));
  assign row_end = (CMPY'(y) == CMPY'(oh_m1));
  assign last    = col_end && row_end;

  // Pack the command: kind, last mark, pixel, write address, column, row
  assign cmd_data = {is_fetch, last, request.pixel_in, wr_addr, x, y};

  // Next positions
  always_comb begin
    wp_next  = wp;
    col_next = col;
    row_next = row;
    if (restart) begin
      wp_next  = '0;
      col_next = '0;
      row_next = '0;
    end else if (accept && !is_fetch) begin
      wp_next = (wr_inc >= NW'(pix_count)) ? '0 : AW'(wr_inc);
    end else if (accept && is_fetch) begin
      if (col_end) begin
        col_next = '0;
        row_next = row_end ? '0 : y + YW'(1);
      end else begin
        col_next = x + XW'(1);
        row_next = y;
      end
    end
  end

  // Hold positions
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      col <= '0;
      row <= '0;
    end else begin
      wp  <= wp_next;
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

/* hdl/tte_back.sv */
// ----------------------------------------------------------------------------
// tte_back
// Executes queued commands: store writes, coordinate mapping, frame reads.
// ----------------------------------------------------------------------------
module tte_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  parameter int SZW  = $clog2(MAX_WIDTH + 1),
  parameter int SZH  = $clog2(MAX_HEIGHT + 1),
  parameter int AW   = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1,
  parameter int CMDW = 2 + 32 + AW + XW + YW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         mode,
  input  logic [SZW-1:0]     sw,
  input  logic [SZH-1:0]     sh,
  input  logic [SZW-1:0]     dw,
  input  logic [SZH-1:0]     dh,
  input  logic [7:0]         ox,
  input  logic [7:0]         oy,
  input  logic [CMDW-1:0]    cmd_data,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [31:0]        ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [31:0]        ram_rdata,
  input  logic               pop,
  output logic               empty,
  output tte_pkg::tte_out_t  result
);

  import tte_pkg::*;

  // Command field offsets
  localparam int X_LO    = YW;
  localparam int A_LO    = YW + XW;
  localparam int D_LO    = YW + XW + AW;
  localparam int LAST_B  = D_LO + PIXEL_W;
  localparam int FETCH_B = LAST_B + 1;

  // Coordinate and divider widths
  localparam int CW0  = (XW > YW) ? XW : YW;
  localparam int CW   = ((CW0 > 8) ? CW0 : 8) + 1;
  localparam int DVX  = XW + SZW;
  localparam int DVY  = YW + SZH;
  localparam int DVW  = (DVX > DVY) ? DVX : DVY;
  localparam int RW   = (SZW > SZH) ? SZW : SZH;
  localparam int SCW  = $clog2(DVW);
  localparam int AFW  = CW + SZW;

  tte_back_state_t state;
  tte_back_state_t state_next;

  logic [XW-1:0]  fx;
  logic [YW-1:0]  fy;
  logic           flast;
  logic [CW-1:0]  sx_r;
  logic [CW-1:0]  sy_r;
  logic [DVW-1:0] quo_x;
  logic [DVW-1:0] quo_y;
  logic [RW-1:0]  rem_x;
  logic [RW-1:0]  rem_y;
  logic [SCW-1:0] step;
  logic           oor_r;
  logic           result_valid;

  logic           head_fetch;
  logic           result_load;
  logic           div_done;
  logic [DVX-1:0] prod_x;
  logic [DVY-1:0] prod_y;
  logic [CW-1:0]  sx_map;
  logic [CW-1:0]  sy_map;
  logic [RW:0]    trial_x;
  logic [RW:0]    trial_y;
  logic           ge_x;
  logic           ge_y;
  logic [RW-1:0]  rem_x_next;
  logic [RW-1:0]  rem_y_next;
  logic [DVW-1:0] quo_x_next;
  logic [DVW-1:0] quo_y_next;
  logic [AFW-1:0] addr_full;
  logic           oor;

  assign head_fetch = (cmd_data[FETCH_B] == OP_FETCH);
  assign empty      = !result_valid;
  assign div_done   = (step == SCW'(DVW - 1));

  // Map output position to source position for the direct modes
  always_comb begin
    case (mode)
      MODE_HMIRROR: begin
        sx_map = CW'(sw) - CW'(1) - CW'(fx);
        sy_map = CW'(fy);
      end
      MODE_VMIRROR: begin
        sx_map = CW'(fx);
        sy_map = CW'(sh) - CW'(1) - CW'(fy);
      end
      MODE_CROP: begin
        sx_map = CW'(ox) + CW'(fx);
        sy_map = CW'(oy) + CW'(fy);
      end
      default: begin
        sx_map = CW'(fx);
        sy_map = CW'(fy);
      end
    endcase
  end

  // Scale numerators
  assign prod_x = fx * sw;
  assign prod_y = fy * sh;

  // One restoring-division step per lane
  always_comb begin
    trial_x    = {rem_x, quo_x[DVW-1]};
    trial_y    = {rem_y, quo_y[DVW-1]};
    ge_x       = (trial_x >= {1'b0, RW'(dw)});
    ge_y       = (trial_y >= {1'b0, RW'(dh)});
    rem_x_next = ge_x ? RW'(trial_x - {1'b0, RW'(dw)}) : RW'(trial_x);
    rem_y_next = ge_y ? RW'(trial_y - {1'b0, RW'(dh)}) : RW'(trial_y);
    quo_x_next = {quo_x[DVW-2:0], ge_x};
    quo_y_next = {quo_y[DVW-2:0], ge_y};
  end

  // Range check and store address
  assign oor       = (sx_r >= CW'(sw)) || (sy_r >= CW'(sh));
  assign addr_full = sy_r * sw + AFW'(sx_r);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty && head_fetch) begin
          state_next = BK_MAP;
        end
      end
      BK_MAP: begin
        state_next = (mode == MODE_SCALE) ? BK_DIV : BK_ADDR;
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_ADDR;
        end
      end
      BK_ADDR: begin
        state_next = BK_READ;
      end
      BK_READ: begin
        if (result_load) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    result_load = 1'b0;
    unique case (state)
      BK_IDLE: begin
        cmd_pop = !cmd_empty;
        ram_we  = !cmd_empty && !head_fetch;
      end
      BK_ADDR: begin
        ram_re = 1'b1;
      end
      BK_READ: begin
        result_load = !result_valid || pop;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  assign ram_waddr = cmd_data[D_LO-1:A_LO];
  assign ram_wdata = cmd_data[LAST_B-1:D_LO];
  assign ram_raddr = AW'(addr_full);

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        fx    <= cmd_data[A_LO-1:X_LO];
        fy    <= cmd_data[X_LO-1:0];
        flast <= cmd_data[LAST_B];
      end
      BK_MAP: begin
        sx_r  <= sx_map;
        sy_r  <= sy_map;
        quo_x <= DVW'(prod_x);
        quo_y <= DVW'(prod_y);
        rem_x <= '0;
        rem_y <= '0;
        step  <= '0;
      end
      BK_DIV: begin
        quo_x <= quo_x_next;
        quo_y <= quo_y_next;
        rem_x <= rem_x_next;
        rem_y <= rem_y_next;
        step  <= step + SCW'(1);
        if (div_done) begin
          sx_r <= CW'(quo_x_next);
          sy_r <= CW'(quo_y_next);
        end
      end
      BK_ADDR: begin
        oor_r <= oor;
      end
      default: begin
        oor_r <= oor_r;
      end
    endcase
  end

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.pixel_out    <= oor_r ? '0 : ram_rdata;
      result.last_pixel   <= flast;
      result.out_of_range <= oor_r;
    end
  end

  // Commands leave the queue only while the sequencer is free
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == BK_IDLE) && !cmd_empty)
    else $error("command popped outside idle or from an empty queue");

  // Read data is used only right after an address was issued
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (state == BK_READ) |-> ($past(state) == BK_ADDR || $past(state) == BK_READ))
    else $error("read state entered without a store address");

  // The divider starts from step zero
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) && ($past(state) == BK_MAP) |-> (step == '0))
    else $error("divider started at a nonzero step");

  // An out-of-range result carries a zero pixel
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_of_range |-> (result.pixel_out == '0))
    else $error("out-of-range result with a nonzero pixel");

endmodule

/* hdl/texture_transform_engine_top.sv */
// ----------------------------------------------------------------------------
// texture_transform_engine_top
// Frame store with copy, mirror, crop and nearest-neighbor scale readout.
// ----------------------------------------------------------------------------
// Write items fill the frame store in raster order; fetch items return the
// next output pixel in raster order, marked on the last pixel of the frame.
// Items pass through a four-entry command queue to a back-end sequencer.
// Write items are taken at one per clock while the command queue has room.
// A fetch passes queue pop, coordinate map, store address and registered
// store read; scale mode adds the one-bit-per-cycle divider, computing
// floor(x*w/dw) and floor(y*h/dh) on DVW bits, where DVW = clog2(MAX_WIDTH)
// + clog2(MAX_WIDTH+1), or the same for the height if larger (17 at the
// defaults). A result waits in an output register while new items keep
// entering the queue. Any write to an existing register restarts the write
// and output positions; size registers of 0 read as 1 and sizes above the
// maximum read as the maximum. The store needs no clearing after reset.
module texture_transform_engine_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  tte_pkg::tte_in_t                    request,
  output logic                                empty,
  input  logic                                pop,
  output tte_pkg::tte_out_t                   result,
  input  logic                                cfg_we,
  input  logic [tte_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tte_pkg::*;

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SZW   = $clog2(MAX_WIDTH + 1);
  localparam int SZH   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMDW  = 2 + PIXEL_W + AW + XW + YW;
  localparam int QUEUE_DEPTH = 4;

  logic [MODE_W-1:0]   mode;
  logic [SZW-1:0]      sw;
  logic [SZH-1:0]      sh;
  logic [SZW-1:0]      dw;
  logic [SZH-1:0]      dh;
  logic [ORIGIN_W-1:0] ox;
  logic [ORIGIN_W-1:0] oy;

  logic [SZW-1:0]      clamp_w;
  logic [SZH-1:0]      clamp_h;
  logic                restart;

  logic                cmd_push;
  logic [CMDW-1:0]     cmd_in;
  logic                cmd_full;
  logic                cmd_pop;
  logic [CMDW-1:0]     cmd_out;
  logic                cmd_empty;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [PIXEL_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [PIXEL_W-1:0]  ram_rdata;

  // Clamp a written size to 1..maximum
  assign clamp_w = (cfg_data == '0) ? SZW'(1) :
                   (32'(cfg_data) > 32'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : SZW'(cfg_data);
  assign clamp_h = (cfg_data == '0) ? SZH'(1) :
                   (32'(cfg_data) > 32'(MAX_HEIGHT)) ? SZH'(MAX_HEIGHT) : SZH'(cfg_data);

  // Decode register index; writes beyond the list change nothing
  always_comb begin
    unique case (cfg_index)
      REG_MODE, REG_SRC_W, REG_SRC_H, REG_DST_W,
      REG_DST_H, REG_CROP_X, REG_CROP_Y: restart = cfg_we;
      default:                           restart = 1'b0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_COPY;
      sw   <= SZW'(1);
      sh   <= SZH'(1);
      dw   <= SZW'(1);
      dh   <= SZH'(1);
      ox   <= '0;
      oy   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode <= cfg_data[MODE_W-1:0];
        REG_SRC_W:  sw   <= clamp_w;
        REG_SRC_H:  sh   <= clamp_h;
        REG_DST_W:  dw   <= clamp_w;
        REG_DST_H:  dh   <= clamp_h;
        REG_CROP_X: ox   <= cfg_data[ORIGIN_W-1:0];
        REG_CROP_Y: oy   <= cfg_data[ORIGIN_W-1:0];
        default:    mode <= mode;
      endcase
    end
  end

  tte_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW),
    .SZW        (SZW),
    .SZH        (SZH),
    .AW         (AW),
    .CMDW       (CMDW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .push     (push),
    .full     (full),
    .request  (request),
    .mode     (mode),
    .sw       (sw),
    .sh       (sh),
    .dw       (dw),
    .dh       (dh),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  tte_fifo #(
    .WIDTH (CMDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  tte_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tte_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW),
    .SZW        (SZW),
    .SZH        (SZH),
    .AW         (AW),
    .CMDW       (CMDW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .sw        (sw),
    .sh        (sh),
    .dw        (dw),
    .dh        (dh),
    .ox        (ox),
    .oy        (oy),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

/* sim/tb_texture_transform_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_texture_transform_engine_top
// Self-checking bench for the texture transform engine.
// ----------------------------------------------------------------------------
// Fills the frame store through write items and fetches output pixels in all
// modes: copy, both mirrors, crop and nearest-neighbor scale. A local pixel
// predictor tracks the store, the write and output positions and the register
// settings, and queues the expected pixel for every accepted fetch. A checker
// compares each popped item field by field. Fetches are only issued when the
// source pixel they map to has been written, or lies outside the image.
// ----------------------------------------------------------------------------
module tb_texture_transform_engine_top;
  import tte_pkg::*;

  localparam int MAX_W        = 256;
  localparam int MAX_H        = 256;
  localparam int DRAIN_CYCLES = 64;
  localparam int FINAL_WAIT   = 100000;

  // Register index past the end of the list, and the top unused mode code
  localparam logic [CFG_INDEX_W-1:0] REG_NONE  = 3'd7;
  localparam logic [MODE_W-1:0]      MODE_LAST = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  tte_in_t                request = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  tte_out_t               result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state
  logic [PIXEL_W-1:0]     pixel_mem [0:MAX_W*MAX_H-1];
  bit                     pixel_valid [0:MAX_W*MAX_H-1];
  int                     wr_pos = 0;
  int                     out_col = 0;
  int                     out_row = 0;
  logic [MODE_W-1:0]      mode_r = MODE_COPY;
  logic [SIZE_REG_W-1:0]  src_w_r = 9'd1;
  logic [SIZE_REG_W-1:0]  src_h_r = 9'd1;
  logic [SIZE_REG_W-1:0]  dst_w_r = 9'd1;
  logic [SIZE_REG_W-1:0]  dst_h_r = 9'd1;
  logic [ORIGIN_W-1:0]    org_x_r = '0;
  logic [ORIGIN_W-1:0]    org_y_r = '0;

  tte_out_t               expected_pixels [$];
  tte_out_t               front_item;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int oor_count = 0;
  int mode_fetches [8];

  texture_transform_engine_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------------

  // Size registers: 0 reads as 1, anything above the maximum reads as the maximum
  function automatic int eff_size(input logic [SIZE_REG_W-1:0] v, input int max_size);
    if (v == '0) return 1;
    return (int'(v) > max_size) ? max_size : int'(v);
  endfunction

  // Map the next output position to a source coordinate
  function automatic void locate_next(output int x, output int y, output int sx,
                                      output int sy, output int ow, output int oh);
    int sw, sh, dw, dh;
    sw = eff_size(src_w_r, MAX_W);
    sh = eff_size(src_h_r, MAX_H);
    dw = eff_size(dst_w_r, MAX_W);
    dh = eff_size(dst_h_r, MAX_H);
    if (mode_r == MODE_CROP || mode_r == MODE_SCALE) begin
      ow = dw;
      oh = dh;
    end else begin
      ow = sw;
      oh = sh;
    end
    x = (out_col < ow) ? out_col : ow - 1;
    y = (out_row < oh) ? out_row : oh - 1;
    case (mode_r)
      MODE_HMIRROR: begin
        sx = sw - 1 - x;
        sy = y;
      end
      MODE_VMIRROR: begin
        sx = x;
        sy = sh - 1 - y;
      end
      MODE_CROP: begin
        sx = int'(org_x_r) + x;
        sy = int'(org_y_r) + y;
      end
      MODE_SCALE: begin
        sx = (x * sw) / dw;
        sy = (y * sh) / dh;
      end
      default: begin
        sx = x;
        sy = y;
      end
    endcase
  endfunction

  // A fetch is safe when it reads a written pixel or falls outside the image
  function automatic bit fetch_safe();
    int x, y, sx, sy, ow, oh, sw, sh;
    sw = eff_size(src_w_r, MAX_W);
    sh = eff_size(src_h_r, MAX_H);
    locate_next(x, y, sx, sy, ow, oh);
    if (sx >= sw || sy >= sh) return 1'b1;
    return pixel_valid[sy * sw + sx];
  endfunction

  function automatic tte_out_t predict_fetch();
    tte_out_t r;
    int x, y, sx, sy, ow, oh, sw, sh;
    sw = eff_size(src_w_r, MAX_W);
    sh = eff_size(src_h_r, MAX_H);
    locate_next(x, y, sx, sy, ow, oh);
    r = '0;
    if (sx >= sw || sy >= sh) begin
      r.out_of_range = 1'b1;
      oor_count++;
    end else begin
      r.pixel_out = pixel_mem[sy * sw + sx];
    end
    // Advance in raster order, wrapping after the last pixel of the frame
    if (x + 1 >= ow) begin
      out_col = 0;
      if (y + 1 >= oh) begin
        out_row = 0;
        r.last_pixel = 1'b1;
      end else begin
        out_row = y + 1;
      end
    end else begin
      out_col = x + 1;
      out_row = y;
    end
    mode_fetches[mode_r]++;
    return r;
  endfunction

  function automatic void store_pixel(input logic [PIXEL_W-1:0] pix);
    int area;
    area = eff_size(src_w_r, MAX_W) * eff_size(src_h_r, MAX_H);
    if (wr_pos >= area) wr_pos = 0;
    pixel_mem[wr_pos] = pix;
    pixel_valid[wr_pos] = 1'b1;
    wr_pos++;
    if (wr_pos >= area) wr_pos = 0;
  endfunction

  // Any listed register restarts both positions; the spare index does nothing
  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:   mode_r = data[MODE_W-1:0];
      REG_SRC_W:  src_w_r = data;
      REG_SRC_H:  src_h_r = data;
      REG_DST_W:  dst_w_r = data;
      REG_DST_H:  dst_h_r = data;
      REG_CROP_X: org_x_r = data[ORIGIN_W-1:0];
      REG_CROP_Y: org_y_r = data[ORIGIN_W-1:0];
      default:    return;
    endcase
    wr_pos = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop, long hold-off on request, in-order check
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_off > 0) begin
      pop <= 1'b0;
      hold_off--;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected item, expected none, got pixel %h last %b oor %b",
                 $time, result.pixel_out, result.last_pixel, result.out_of_range);
        error_count++;
      end else begin
        front_item = expected_pixels.pop_front();
        results_checked++;
        if (result.pixel_out !== front_item.pixel_out) begin
          $display("%0t: pixel_out mismatch, expected %h, got %h",
                   $time, front_item.pixel_out, result.pixel_out);
          error_count++;
        end
        if (result.last_pixel !== front_item.last_pixel) begin
          $display("%0t: last_pixel mismatch, expected %b, got %b",
                   $time, front_item.last_pixel, result.last_pixel);
          error_count++;
        end
        if (result.out_of_range !== front_item.out_of_range) begin
          $display("%0t: out_of_range mismatch, expected %b, got %b",
                   $time, front_item.out_of_range, result.out_of_range);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item; push stays high on return so back-to-back items need no gap
  task automatic send_item(input logic op, input logic [PIXEL_W-1:0] pix);
    tte_in_t item;
    int gap;
    item.opcode = op;
    item.pixel_in = pix;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    request <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op == OP_FETCH) begin
      expected_pixels.push_back(predict_fetch());
    end else begin
      store_pixel(pix);
    end
    items_sent++;
  endtask

  // Fetch when the mapped pixel is safe to read, else write a fresh pixel
  task automatic send_random_op(input bit want_fetch);
    if (want_fetch && fetch_safe()) begin
      send_item(OP_FETCH, $urandom);
    end else begin
      send_item(OP_WRITE, $urandom);
    end
  endtask

  task automatic fetch_burst(input int n);
    repeat (n) send_random_op(1'b1);
  endtask

  // Drop push, wait for every expected item, then let queued writes finish
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic load_setup(input logic [MODE_W-1:0] m,
                            input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                            input logic [CFG_DATA_W-1:0] dw, input logic [CFG_DATA_W-1:0] dh,
                            input logic [CFG_DATA_W-1:0] ox, input logic [CFG_DATA_W-1:0] oy);
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_DST_W, dw);
    write_reg(REG_DST_H, dh);
    write_reg(REG_CROP_X, ox);
    write_reg(REG_CROP_Y, oy);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'($urandom_range(MAX_W + 1, 511));
    if (r == 2) return CFG_DATA_W'($urandom_range(9, MAX_W));
    return CFG_DATA_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_origin();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 9'd255;
    if (r == 2) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 4));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setup, a small 3x2 image through every mode, spare index, unused mode
  task automatic test_directed();
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_FETCH, 32'h0000_0000);
    send_item(OP_WRITE, 32'h0000_0000);
    send_item(OP_FETCH, 32'hFFFF_FFFF);
    wait_drained();
    load_setup(MODE_COPY, 9'd3, 9'd2, 9'd2, 9'd2, 9'd2, 9'd1);
    for (int i = 0; i < 6; i++) begin
      send_item(OP_WRITE, (i % 2 == 0) ? 32'hAAAA_AA00 + i : 32'h5555_5500 + i);
    end
    fetch_burst(1);
    wait_drained();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_HMIRROR));
    fetch_burst(2);
    wait_drained();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_VMIRROR));
    fetch_burst(1);
    // Crop window hangs off the right and bottom edges
    wait_drained();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_CROP));
    fetch_burst(4);
    // The spare index must not restart the output position
    wait_drained();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_SCALE));
    fetch_burst(2);
    wait_drained();
    write_reg(REG_NONE, 9'h1FF);
    fetch_burst(2);
    wait_drained();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_LAST));
    fetch_burst(1);
  endtask

  // Largest sizes, oversized and zero size registers, origins at the far edge
  task automatic test_extreme_sizes();
    wait_drained();
    load_setup(MODE_COPY, 9'd256, 9'd1, 9'd1, 9'd1, 9'd0, 9'd0);
    repeat (MAX_W) send_item(OP_WRITE, $urandom);
    fetch_burst(6);
    wait_drained();
    load_setup(MODE_HMIRROR, 9'h1FF, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
    fetch_burst(6);
    wait_drained();
    load_setup(MODE_VMIRROR, 9'd1, 9'd256, 9'd1, 9'd1, 9'd0, 9'd0);
    fetch_burst(6);
    wait_drained();
    load_setup(MODE_CROP, 9'd256, 9'd1, 9'h1FF, 9'd0, 9'd255, 9'd0);
    fetch_burst(4);
    wait_drained();
    load_setup(MODE_CROP, 9'd1, 9'h1FF, 9'd1, 9'd2, 9'd0, 9'd255);
    fetch_burst(3);
    wait_drained();
    load_setup(MODE_SCALE, 9'd256, 9'd1, 9'd3, 9'd1, 9'd0, 9'd0);
    fetch_burst(4);
    wait_drained();
    load_setup(MODE_SCALE, 9'd1, 9'h1FF, 9'h1FF, 9'd3, 9'd0, 9'd0);
    fetch_burst(8);
    wait_drained();
    load_setup(MODE_SCALE, 9'd256, 9'd1, 9'd0, 9'd256, 9'd0, 9'd0);
    fetch_burst(8);
  endtask

  // Stall the result side long enough to fill the block and back up push
  task automatic test_backpressure();
    wait_drained();
    load_setup(MODE_COPY, 9'd4, 9'd4, 9'd1, 9'd1, 9'd0, 9'd0);
    repeat (16) send_item(OP_WRITE, $urandom);
    hold_off = 400;
    fetch_burst(30);
    wait_drained();
  endtask

  // Random setups; most phases first write pixels, up to a full image, then mostly fetch
  task automatic test_random_mix(input int phases, input int per_phase);
    logic [MODE_W-1:0] m;
    int fill, fetch_pct, done;
    for (int p = 0; p < phases; p++) begin
      wait_drained();
      m = MODE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(MODE_SCALE + 1, MODE_LAST)
                                              : $urandom_range(MODE_COPY, MODE_SCALE));
      load_setup(m, pick_size(), pick_size(), pick_size(), pick_size(),
                 pick_origin(), pick_origin());
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom));
      done = 0;
      if ($urandom_range(0, 4) != 0) begin
        fill = eff_size(src_w_r, MAX_W) * eff_size(src_h_r, MAX_H);
        if (fill > per_phase) fill = per_phase;
        repeat (fill) send_item(OP_WRITE, $urandom);
        done = fill;
        fetch_pct = 85;
      end else begin
        fetch_pct = 50;
      end
      while (done < per_phase) begin
        send_random_op($urandom_range(0, 99) < fetch_pct);
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int guard;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 46;
    test_directed();
    test_extreme_sizes();
    test_backpressure();
    test_random_mix(6, 20);

    send_idle_pct = 46;
    recv_idle_pct = 34;
    test_random_mix(6, 20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(6, 20);

    // Drain with a bound, then watch for stray items
    @(negedge clk);
    push <= 1'b0;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < FINAL_WAIT) begin
      @(negedge clk);
      guard++;
    end
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_pixels.size());
      error_count += expected_pixels.size();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d items, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("Fetches: copy %0d, h-mirror %0d, v-mirror %0d, crop %0d (%0d outside), %0s %0d",
             mode_fetches[MODE_COPY], mode_fetches[MODE_HMIRROR], mode_fetches[MODE_VMIRROR],
             mode_fetches[MODE_CROP], oor_count, "scale", mode_fetches[MODE_SCALE]);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
